[src/svdl_pkg.sv]
`timescale 1ns / 1ps
package svdl_pkg;

   localparam int STORE_DEPTH_DEFAULT     = 4096;
   localparam int SAMPLE_BITS_DEFAULT     = 24;
   localparam int SINE_TABLE_SIZE_DEFAULT = 1024;

   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 31;
   localparam int PHASE_BITS      = 32;
   localparam int PHASE_STEP_BITS = 31;
   localparam int DELAY_BITS      = 20;
   localparam int MIX_BITS        = 16;
   localparam int SINE_BITS       = 16;
   localparam int FRAC_BITS       = 8;

   localparam logic [PHASE_STEP_BITS-1:0] PHASE_STEP_RESET = 31'd447392;
   localparam logic [DELAY_BITS-1:0]      BASE_DELAY_RESET = 20'd61440;
   localparam logic [DELAY_BITS-1:0]      MOD_DEPTH_RESET  = 20'd24576;
   localparam logic [MIX_BITS-1:0]        WET_MIX_RESET    = 16'd32768;

   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [MIX_BITS:0]     MIX_ONE      = 17'd32768;

   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint COEF_A1 = 64'sd1686629713;
   localparam longint COEF_A3 = -64'sd693598668;
   localparam longint COEF_A5 = 64'sd85569306;
   localparam longint COEF_A7 = -64'sd4858527;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LFO_PHASE_STEP = 2'd0,
      CSR_BASE_DELAY     = 2'd1,
      CSR_MOD_DEPTH      = 2'd2,
      CSR_WET_MIX        = 2'd3
   } svdl_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_DELAY,
      ST_READ,
      ST_INTERP,
      ST_MIX,
      ST_FINAL
   } svdl_state_type;

   function automatic longint mul_q30(input longint a, input longint x);
      longint mag;
      longint m;
      mag = (a < 0) ? -a : a;
      m = (mag * x) >>> 30;
      return (a < 0) ? -m : m;
   endfunction

   // Quarter-wave sine of x in Q30 (one means a quarter turn), result in Q15.
   function automatic longint quarter_sine(input longint x);
      longint x2;
      longint p;
      longint y;
      x2 = (x * x) >>> 30;
      p = COEF_A7;
      p = COEF_A5 + mul_q30(p, x2);
      p = COEF_A3 + mul_q30(p, x2);
      p = COEF_A1 + mul_q30(p, x2);
      y = mul_q30(p, x);
      if (y <= 0) begin
         return 0;
      end
      y = (y + 64'sd16384) >>> 15;
      if (y > 64'sd32767) begin
         return 64'sd32767;
      end
      return y;
   endfunction

endpackage

[src/svdl_stream_if.sv]
`timescale 1ns / 1ps
interface svdl_req_if #(
   parameter int SAMPLE_BITS = svdl_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface svdl_rsp_if #(
   parameter int SAMPLE_BITS = svdl_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

[src/stereo_vibrato_delay_line.sv]
`timescale 1ns / 1ps
// The sequencer walks each request through the sine fetch, delay, store read, interpolation and
// mix steps one after another, then holds the result until the output register is free; only
// then is a new request taken, so requests never overlap inside the block.
// Reset is synchronous and active high: it clears the sequencer, write pointer, LFO phase and
// output valid, and loads the register defaults. Store entries never written read as zero.
module stereo_vibrato_delay_line #(
   parameter int STORE_DEPTH     = svdl_pkg::STORE_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS     = svdl_pkg::SAMPLE_BITS_DEFAULT,
   parameter int SINE_TABLE_SIZE = svdl_pkg::SINE_TABLE_SIZE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   svdl_req_if.sink                               req_stream,
   svdl_rsp_if.source                             rsp_stream,
   input  logic                                   csr_write,
   input  logic [svdl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [svdl_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int SB      = SAMPLE_BITS;
   localparam int FRAC    = svdl_pkg::FRAC_BITS;
   localparam int SW      = svdl_pkg::SINE_BITS;
   localparam int PH_W    = svdl_pkg::PHASE_BITS;
   localparam int DL_W    = svdl_pkg::DELAY_BITS;
   localparam int MX_W    = svdl_pkg::MIX_BITS;
   localparam int DEPTH_W = $clog2(STORE_DEPTH);
   localparam int SINE_W  = $clog2(SINE_TABLE_SIZE);
   localparam int SIZE_W  = $clog2(SINE_TABLE_SIZE + 1);
   localparam int IDXP_W  = PH_W + SIZE_W;
   localparam int POS_W   = DEPTH_W + FRAC;
   localparam int PROD_W  = DL_W + 1 + SW;
   localparam int SWING_W = PROD_W - 15;
   localparam int DR_W    = ((POS_W + 1 > DL_W + 3) ? POS_W + 1 : DL_W + 3) + 1;
   localparam int INT_W   = SB + 11;
   localparam int MS_W    = SB + 19;
   localparam int RND_W   = MS_W - 15;

   localparam logic [POS_W+1:0] SPAN = (POS_W + 2)'(STORE_DEPTH) << FRAC;
   localparam logic [POS_W-1:0] DELAY_MAX = POS_W'((STORE_DEPTH - 1) * 256);
   localparam logic signed [DR_W-1:0] DELAY_MAX_EXT = $signed({{(DR_W - POS_W){1'b0}}, DELAY_MAX});
   localparam logic [DEPTH_W-1:0] LAST_ENTRY = DEPTH_W'(STORE_DEPTH - 1);
   localparam logic signed [RND_W-1:0] SAT_HI = $signed({{(RND_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}});
   localparam logic signed [RND_W-1:0] SAT_LO = $signed({{(RND_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}});

   typedef logic signed [SW-1:0] sine_rom_type [SINE_TABLE_SIZE];

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      longint p;
      longint r;
      longint s;
      longint quad;
      for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
         p = (longint'(i) <<< 32) / SINE_TABLE_SIZE;
         quad = (p >>> 30) & 64'sd3;
         r = p & (svdl_pkg::Q30_ONE - 1);
         if (quad[0]) begin
            s = svdl_pkg::quarter_sine(svdl_pkg::Q30_ONE - r);
         end else begin
            s = svdl_pkg::quarter_sine(r);
         end
         if (quad[1]) begin
            s = -s;
         end
         rom[i] = s[SW-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   svdl_pkg::svdl_state_type state_ff, state_in;

   logic [svdl_pkg::PHASE_STEP_BITS-1:0] phase_step_ff;
   logic [DL_W-1:0]                      base_delay_ff;
   logic [DL_W-1:0]                      mod_depth_ff;
   logic [MX_W-1:0]                      wet_mix_ff;

   logic [DEPTH_W-1:0] wp_ff;
   logic               wrapped_ff;
   logic [PH_W-1:0]    phase_ff;

   logic [SB-1:0] left_store_ff  [STORE_DEPTH];
   logic [SB-1:0] right_store_ff [STORE_DEPTH];

   logic signed [SB-1:0]     dry_ff    [2];
   logic signed [SW-1:0]     sine_ff   [2];
   logic signed [PROD_W-1:0] prod_ff   [2];
   logic [POS_W-1:0]         delay_ff  [2];
   logic signed [SB-1:0]     tap0_ff   [2];
   logic signed [SB-1:0]     tap1_ff   [2];
   logic                     valid0_ff [2];
   logic                     valid1_ff [2];
   logic [FRAC-1:0]          frac_ff   [2];
   logic signed [SB-1:0]     wet_ff    [2];
   logic signed [MS_W-1:0]   mixp_ff   [2];

   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_left_ff;
   logic signed [SB-1:0] rsp_right_ff;

   logic req_fire;
   logic out_free;
   logic load_out;

   logic [PH_W-1:0]          lane_phase [2];
   logic [IDXP_W-1:0]        idx_prod   [2];
   logic [SINE_W-1:0]        sine_idx   [2];
   logic signed [PROD_W-1:0] prod_in    [2];
   logic signed [PROD_W-1:0] prod_rnd   [2];
   logic signed [DR_W-1:0]   delay_raw  [2];
   logic [POS_W-1:0]         delay_in   [2];
   logic [POS_W+1:0]         pos_sum    [2];
   logic [POS_W+1:0]         pos_wrap   [2];
   logic [DEPTH_W-1:0]       addr0_in   [2];
   logic [DEPTH_W-1:0]       addr1_in   [2];
   logic [FRAC-1:0]          frac_in    [2];
   logic signed [SB-1:0]     s0         [2];
   logic signed [SB-1:0]     s1         [2];
   logic [FRAC:0]            weight0    [2];
   logic signed [INT_W-1:0]  interp_sum [2];
   logic signed [SB-1:0]     wet_in     [2];
   logic signed [MS_W-1:0]   mixp_in    [2];
   logic signed [MS_W-1:0]   mix_rnd    [2];
   logic signed [RND_W-1:0]  mix_shift  [2];
   logic signed [SB-1:0]     out_in     [2];
   logic [MX_W:0]            mix_amt;
   logic [MX_W:0]            dry_amt;

   assign req_fire = req_stream.valid && req_stream.ready;
   assign out_free = !rsp_valid_ff || rsp_stream.ready;
   assign load_out = (state_ff == svdl_pkg::ST_FINAL) && out_free;

   assign rsp_stream.valid     = rsp_valid_ff;
   assign rsp_stream.left_out  = rsp_left_ff;
   assign rsp_stream.right_out = rsp_right_ff;

   always_comb begin
      state_in = state_ff;
      req_stream.ready = 1'b0;
      unique case (state_ff)
         svdl_pkg::ST_IDLE: begin
            req_stream.ready = 1'b1;
            if (req_stream.valid) begin
               state_in = svdl_pkg::ST_MULT;
            end
         end
         svdl_pkg::ST_MULT:   state_in = svdl_pkg::ST_DELAY;
         svdl_pkg::ST_DELAY:  state_in = svdl_pkg::ST_READ;
         svdl_pkg::ST_READ:   state_in = svdl_pkg::ST_INTERP;
         svdl_pkg::ST_INTERP: state_in = svdl_pkg::ST_MIX;
         svdl_pkg::ST_MIX:    state_in = svdl_pkg::ST_FINAL;
         svdl_pkg::ST_FINAL: begin
            if (out_free) begin
               state_in = svdl_pkg::ST_IDLE;
            end
         end
         default: state_in = svdl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svdl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= svdl_pkg::PHASE_STEP_RESET;
         base_delay_ff <= svdl_pkg::BASE_DELAY_RESET;
         mod_depth_ff  <= svdl_pkg::MOD_DEPTH_RESET;
         wet_mix_ff    <= svdl_pkg::WET_MIX_RESET;
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (svdl_pkg::svdl_csr_type'(csr_index))
               svdl_pkg::CSR_LFO_PHASE_STEP: phase_step_ff <= csr_data[svdl_pkg::PHASE_STEP_BITS-1:0];
               svdl_pkg::CSR_BASE_DELAY:     base_delay_ff <= csr_data[DL_W-1:0];
               svdl_pkg::CSR_MOD_DEPTH:      mod_depth_ff  <= csr_data[DL_W-1:0];
               svdl_pkg::CSR_WET_MIX:        wet_mix_ff    <= csr_data[MX_W-1:0];
            endcase
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_ff + {1'b0, phase_step_ff};
            wrapped_ff   <= wrapped_ff || (wp_ff == LAST_ENTRY);
            if (wp_ff == LAST_ENTRY) begin
               wp_ff <= '0;
            end else begin
               wp_ff <= wp_ff + DEPTH_W'(1);
            end
         end else if (rsp_stream.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      lane_phase[0] = phase_ff;
      lane_phase[1] = phase_ff + svdl_pkg::QUARTER_TURN;
      mix_amt = (wet_mix_ff > svdl_pkg::MIX_ONE[MX_W-1:0] && wet_mix_ff[MX_W-1] == 1'b1)
                ? svdl_pkg::MIX_ONE : {1'b0, wet_mix_ff};
      dry_amt = svdl_pkg::MIX_ONE - mix_amt;
      for (int l = 0; l < 2; l++) begin
         idx_prod[l] = {{SIZE_W{1'b0}}, lane_phase[l]} * IDXP_W'(SINE_TABLE_SIZE);
         sine_idx[l] = idx_prod[l][PH_W +: SINE_W];

         prod_in[l] = $signed({1'b0, mod_depth_ff}) * sine_ff[l];

         prod_rnd[l] = prod_ff[l] + $signed(PROD_W'(16384));
         delay_raw[l] = DR_W'($signed({1'b0, base_delay_ff}))
                        + DR_W'($signed(prod_rnd[l][PROD_W-1 -: SWING_W]));
         if (delay_raw[l] < 0) begin
            delay_in[l] = '0;
         end else if (delay_raw[l] > DELAY_MAX_EXT) begin
            delay_in[l] = DELAY_MAX;
         end else begin
            delay_in[l] = delay_raw[l][POS_W-1:0];
         end

         pos_sum[l] = {2'b00, wp_ff, {FRAC{1'b0}}} + SPAN - {2'b00, delay_ff[l]};
         pos_wrap[l] = (pos_sum[l] >= SPAN) ? pos_sum[l] - SPAN : pos_sum[l];
         addr0_in[l] = pos_wrap[l][POS_W-1:FRAC];
         frac_in[l] = pos_wrap[l][FRAC-1:0];
         addr1_in[l] = (addr0_in[l] == LAST_ENTRY) ? '0 : addr0_in[l] + DEPTH_W'(1);

         s0[l] = valid0_ff[l] ? tap0_ff[l] : '0;
         s1[l] = valid1_ff[l] ? tap1_ff[l] : '0;
         weight0[l] = (FRAC + 1)'(256) - {1'b0, frac_ff[l]};
         interp_sum[l] = s0[l] * $signed({1'b0, weight0[l]})
                         + s1[l] * $signed({2'b00, frac_ff[l]});
         interp_sum[l] = interp_sum[l] + $signed(INT_W'(128));
         wet_in[l] = interp_sum[l][FRAC +: SB];

         mixp_in[l] = wet_ff[l] * $signed({1'b0, mix_amt}) + dry_ff[l] * $signed({1'b0, dry_amt});

         mix_rnd[l] = mixp_ff[l] + $signed(MS_W'(16384));
         mix_shift[l] = mix_rnd[l][MS_W-1:15];
         if (mix_shift[l] > SAT_HI) begin
            out_in[l] = SAT_HI[SB-1:0];
         end else if (mix_shift[l] < SAT_LO) begin
            out_in[l] = SAT_LO[SB-1:0];
         end else begin
            out_in[l] = mix_shift[l][SB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         sine_ff[l] <= SINE_ROM[sine_idx[l]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_store_ff[wp_ff]  <= req_stream.left_in;
         right_store_ff[wp_ff] <= req_stream.right_in;
      end
      if (state_ff == svdl_pkg::ST_READ) begin
         tap0_ff[0] <= left_store_ff[addr0_in[0]];
         tap1_ff[0] <= left_store_ff[addr1_in[0]];
         tap0_ff[1] <= right_store_ff[addr0_in[1]];
         tap1_ff[1] <= right_store_ff[addr1_in[1]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dry_ff[0] <= req_stream.left_in;
         dry_ff[1] <= req_stream.right_in;
      end
      for (int l = 0; l < 2; l++) begin
         if (state_ff == svdl_pkg::ST_MULT) begin
            prod_ff[l] <= prod_in[l];
         end
         if (state_ff == svdl_pkg::ST_DELAY) begin
            delay_ff[l] <= delay_in[l];
         end
         if (state_ff == svdl_pkg::ST_READ) begin
            frac_ff[l]   <= frac_in[l];
            valid0_ff[l] <= wrapped_ff || (addr0_in[l] <= wp_ff);
            valid1_ff[l] <= wrapped_ff || (addr1_in[l] <= wp_ff);
         end
         if (state_ff == svdl_pkg::ST_INTERP) begin
            wet_ff[l] <= wet_in[l];
         end
         if (state_ff == svdl_pkg::ST_MIX) begin
            mixp_ff[l] <= mixp_in[l];
         end
      end
      if (load_out) begin
         rsp_left_ff  <= out_in[0];
         rsp_right_ff <= out_in[1];
      end
   end

endmodule

[tb/stereo_vibrato_checker.sv]
`timescale 1ns / 1ps
// Watches the request, result and register ports of the stereo vibrato delay line,
// keeps its own copy of the delay stores, write pointer, LFO phase and registers,
// predicts the mixed pair for every accepted request and compares each accepted
// result with the oldest prediction.
module stereo_vibrato_checker (
   input  logic                                clock,
   input  logic                                reset,
   svdl_req_if                                 req_stream,
   svdl_rsp_if                                 rsp_stream,
   input  logic                                csr_write,
   input  logic [svdl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [svdl_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  mismatches,
   output int                                  pending
);
   import svdl_pkg::*;

   localparam int     DEPTH      = STORE_DEPTH_DEFAULT;
   localparam int     SAMPLE_W   = SAMPLE_BITS_DEFAULT;
   localparam int     LUT_SIZE   = SINE_TABLE_SIZE_DEFAULT;
   localparam longint DELAY_CEIL = longint'(DEPTH - 1) * 256;
   localparam longint SAMPLE_HI  = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_pair_t;

   int                         sine_lut [LUT_SIZE];
   logic signed [SAMPLE_W-1:0] left_hist [DEPTH];
   logic signed [SAMPLE_W-1:0] right_hist [DEPTH];
   int                         wr_ptr;
   logic [PHASE_BITS-1:0]      lfo_ph;
   logic [PHASE_STEP_BITS-1:0] phase_step;
   logic [DELAY_BITS-1:0]      base_dly;
   logic [DELAY_BITS-1:0]      swing;
   logic [MIX_BITS-1:0]        wet_share;

   stereo_pair_t pending_outputs[$];
   stereo_pair_t want;
   stereo_pair_t got;

   function automatic longint q30_scale(input longint a, input longint x);
      longint mag;
      mag = (a < 0) ? -a : a;
      mag = (mag * x) >>> 30;
      return (a < 0) ? -mag : mag;
   endfunction

   function automatic longint quarter_wave(input longint x);
      longint x2;
      longint p;
      longint y;
      x2 = (x * x) >>> 30;
      p = COEF_A5 + q30_scale(COEF_A7, x2);
      p = COEF_A3 + q30_scale(p, x2);
      p = COEF_A1 + q30_scale(p, x2);
      y = q30_scale(p, x);
      if (y <= 0) begin
         return 0;
      end
      y = (y + 64'sd16384) >>> 15;
      return (y > 64'sd32767) ? 64'sd32767 : y;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] vibrato_tap(input bit right_ch,
                                                              input longint dry,
                                                              input logic [31:0] phase);
      logic [63:0] scaled;
      longint      s, d, pos, s0, s1, wet, mix, acc;
      int          i0, i1, f;
      scaled = {32'd0, phase} * LUT_SIZE;
      s = sine_lut[scaled[63:32]];
      d = longint'(base_dly) + ((longint'(swing) * s + 64'sd16384) >>> 15);
      if (d < 0) begin
         d = 0;
      end
      if (d > DELAY_CEIL) begin
         d = DELAY_CEIL;
      end
      pos = (longint'(wr_ptr) * 256 + longint'(DEPTH) * 256 - d) % (longint'(DEPTH) * 256);
      i0 = int'(pos >>> 8) % DEPTH;
      f = int'(pos & 255);
      i1 = (i0 + 1) % DEPTH;
      s0 = right_ch ? right_hist[i0] : left_hist[i0];
      s1 = right_ch ? right_hist[i1] : left_hist[i1];
      wet = (s0 * (256 - f) + s1 * f + 128) >>> 8;
      mix = (wet_share > MIX_ONE) ? 32768 : longint'(wet_share);
      acc = (mix * wet + (32768 - mix) * dry + 64'sd16384) >>> 15;
      if (acc > SAMPLE_HI) begin
         acc = SAMPLE_HI;
      end
      if (acc < SAMPLE_LO) begin
         acc = SAMPLE_LO;
      end
      return acc[SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   initial begin : build_lut
      longint p;
      longint r;
      longint s;
      mismatches = 0;
      pending = 0;
      for (int i = 0; i < LUT_SIZE; i++) begin
         p = (longint'(i) <<< 32) / LUT_SIZE;
         r = p & (Q30_ONE - 1);
         s = ((p >>> 30) & 1) ? quarter_wave(Q30_ONE - r) : quarter_wave(r);
         sine_lut[i] = ((p >>> 31) & 1) ? -s : s;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            left_hist[i] = '0;
            right_hist[i] = '0;
         end
         wr_ptr = 0;
         lfo_ph = '0;
         phase_step = PHASE_STEP_RESET;
         base_dly = BASE_DELAY_RESET;
         swing = MOD_DEPTH_RESET;
         wet_share = WET_MIX_RESET;
         pending_outputs.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LFO_PHASE_STEP: phase_step = csr_data[PHASE_STEP_BITS-1:0];
               CSR_BASE_DELAY:     base_dly = csr_data[DELAY_BITS-1:0];
               CSR_MOD_DEPTH:      swing = csr_data[DELAY_BITS-1:0];
               CSR_WET_MIX:        wet_share = csr_data[MIX_BITS-1:0];
               default: ;
            endcase
         end
         if (req_stream.valid && req_stream.ready) begin
            left_hist[wr_ptr] = req_stream.left_in;
            right_hist[wr_ptr] = req_stream.right_in;
            want.left = vibrato_tap(1'b0, longint'(req_stream.left_in), lfo_ph);
            want.right = vibrato_tap(1'b1, longint'(req_stream.right_in), lfo_ph + QUARTER_TURN);
            pending_outputs.push_back(want);
            wr_ptr = (wr_ptr + 1) % DEPTH;
            lfo_ph = lfo_ph + phase_step;
         end
         if (rsp_stream.valid && rsp_stream.ready) begin
            got.left = rsp_stream.left_out;
            got.right = rsp_stream.right_out;
            if (pending_outputs.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0d with no request outstanding",
                                         got.left, got.right));
            end else begin
               want = pending_outputs.pop_front();
               if (got.left !== want.left) begin
                  report_mismatch($sformatf("left_out %0d, predicted %0d", got.left, want.left));
               end
               if (got.right !== want.right) begin
                  report_mismatch($sformatf("right_out %0d, predicted %0d",
                                            got.right, want.right));
               end
            end
         end
      end
      pending = pending_outputs.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int SAMPLE_W    = svdl_pkg::SAMPLE_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 700;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write;
   logic [svdl_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [svdl_pkg::CSR_DATA_BITS-1:0]  csr_data;
   int                                  mismatches;
   int                                  pending;
   int                                  cycle_count = 0;
   int                                  burst_left = 0;
   int                                  sent = 0;

   logic [SAMPLE_W-1:0] extremes [6] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                         24'hFFFFFF, 24'h555555, 24'hAAAAAA};

   svdl_req_if req_stream ();
   svdl_rsp_if rsp_stream ();

   stereo_vibrato_delay_line DUT (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   stereo_vibrato_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] next_sample(input int kind, input int n);
      int pick;
      pick = $urandom_range(0, 9);
      if (kind == 1 || (kind == 2 && pick >= 7 && pick < 9)) begin
         return extremes[(kind == 1) ? n % 6 : $urandom_range(0, 5)];
      end
      if (kind == 2 && pick == 9) begin
         return SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
      end
      return SAMPLE_W'($urandom);
   endfunction

   task automatic send_items(input int count, input int kind);
      int gap;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
               req_stream.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
         end
         req_stream.valid <= 1'b1;
         req_stream.left_in <= next_sample(kind, i);
         req_stream.right_in <= next_sample(kind, i + 1);
         do @(posedge clock); while (!req_stream.ready);
         burst_left--;
         sent++;
      end
      req_stream.valid <= 1'b0;
   endtask

   task automatic drain(input int settle);
      do @(negedge clock); while (pending != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [30:0] step, input logic [19:0] base,
                                 input logic [19:0] depth, input logic [15:0] mix);
      svdl_pkg::svdl_csr_type idx [4] = '{svdl_pkg::CSR_LFO_PHASE_STEP,
                                          svdl_pkg::CSR_BASE_DELAY,
                                          svdl_pkg::CSR_MOD_DEPTH,
                                          svdl_pkg::CSR_WET_MIX};
      logic [30:0]            value [4];
      value = '{step, 31'(base), 31'(depth), 31'(mix)};
      for (int k = 0; k < 4; k++) begin
         csr_write <= 1'b1;
         csr_index <= idx[k];
         csr_data <= value[k];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Receiver: changing stall patterns, plus one long hold-off once traffic is flowing.
   initial begin
      int  served;
      int  mode;
      int  mode_left;
      int  hold_left;
      int  tick;
      bit  hold_done;
      served = 0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      hold_done = 1'b0;
      rsp_stream.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (rsp_stream.valid && rsp_stream.ready) begin
            served++;
         end
         if (!hold_done && served >= 200) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stream.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_stream.ready <= 1'b1;
               1: rsp_stream.ready <= $urandom_range(0, 1);
               2: rsp_stream.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_stream.ready <= (tick % 5) < 2;
            endcase
         end
      end
   end

   initial begin
      logic [30:0] step;
      logic [19:0] base;
      logic [19:0] depth;
      logic [15:0] mix;
      int          count;
      req_stream.valid <= 1'b0;
      req_stream.left_in <= '0;
      req_stream.right_in <= '0;
      csr_write <= 1'b0;
      csr_index <= svdl_pkg::CSR_LFO_PHASE_STEP;
      csr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_items(2, 1);
      drain(8);
      apply_settings(31'd0, 20'd0, 20'd0, 16'd32768);
      send_items(6, 1);
      drain(8);
      apply_settings(31'd0, 20'd896, 20'd0, 16'd16384);
      send_items(6, 1);
      drain(8);
      apply_settings(31'h7FFF_FFFF, 20'd256, 20'hFFFFF, 16'd0);
      send_items(4, 1);
      drain(8);
      apply_settings(31'h4000_0000, 20'hFFFFF, 20'd0, 16'hFFFF);
      send_items(4, 1);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: step = '0;
            1: step = 31'h7FFF_FFFF;
            2: step = 31'($urandom_range(0, 1 << 22));
            default: step = 31'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: base = '0;
            1: base = 20'hFFFFF;
            2: base = 20'($urandom);
            default: base = 20'($urandom_range(0, 64 * 256));
         endcase
         case ($urandom_range(0, 5))
            0: depth = '0;
            1: depth = 20'hFFFFF;
            2: depth = 20'($urandom);
            3: depth = 20'($urandom_range(0, 32 * 256));
            default: depth = 20'($urandom_range(0, base));
         endcase
         case ($urandom_range(0, 6))
            0: mix = '0;
            1: mix = 16'd32768;
            2: mix = 16'hFFFF;
            3: mix = 16'($urandom_range(32769, 65535));
            default: mix = 16'($urandom_range(0, 32768));
         endcase
         drain(8);
         apply_settings(step, base, depth, mix);
         count = $urandom_range(40, 110);
         if (count > RANDOM_ITEMS - sent) begin
            count = RANDOM_ITEMS - sent;
         end
         send_items(count, 2);
      end

      drain(20);
      if (mismatches == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
src/svdl_pkg.sv
src/svdl_stream_if.sv
src/stereo_vibrato_delay_line.sv
tb/stereo_vibrato_checker.sv
tb/tb.sv
